@@ src/dsa_pkg.sv @@
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types, constants and helpers of the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int unsigned ADDR_W        = 64;
  localparam int unsigned STRIDE_W      = 16;
  localparam int unsigned COUNT_W       = 11;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned MAX_SLOTS_DEF = 1024;

  localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd32;
  localparam logic [COUNT_W-1:0]  COUNT_RST  = 11'd1024;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPU_BASE   = 2'd0,
    CFG_GPU_BASE   = 2'd1,
    CFG_SLOT_STRIDE = 2'd2,
    CFG_SLOT_COUNT = 2'd3
  } cfg_idx_t;

  // slot count clipped to the stack depth
  function automatic logic [31:0] dsa_eff_count(logic [COUNT_W-1:0] cnt,
                                                int unsigned max_slots);
    logic [31:0] c;
    c = 32'(cnt);
    return (c > max_slots) ? 32'(max_slots) : c;
  endfunction

endpackage

@@ src/dsa_ram.sv @@
// ----------------------------------------------------------------------------
// dsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsa_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/dsa_div.sv @@
// ----------------------------------------------------------------------------
// dsa_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in QW bits (upper STRIDE_W dividend bits below the divisor).
// ----------------------------------------------------------------------------
module dsa_div
  import dsa_pkg::*;
#(
  parameter int unsigned QW = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [QW+STRIDE_W-1:0] dividend,
  input  logic [STRIDE_W-1:0]    divisor,
  output logic                   done,
  output logic [QW-1:0]          quotient
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [STRIDE_W-1:0] rem_r;
  logic [QW-1:0]       quo_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [STRIDE_W:0]   trial;
  logic                ge;
  logic [STRIDE_W:0]   diff;

  assign trial = {rem_r, quo_r[QW-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
        rem_r  <= dividend[QW+STRIDE_W-1:QW];
        quo_r  <= dividend[QW-1:0];
      end else if (busy_r) begin
        rem_r <= ge ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
        // low dividend bits shift out on top, quotient bits shift in below
        quo_r <= QW'({quo_r, ge});
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ src/descriptor_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// Hands out fixed-size slots from a LIFO stack of free slot indices held in
// RAM; allocate pops and returns host/device addresses, free pushes back.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_ready   | in_mode, in_host_handle, in_device_handle
//  out     | out | out_valid / out_ready | out_status, out_host_addr, out_device_addr
//  cfg     | in  | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One item at a time. Allocate: stack RAM read, index * stride, base add,
// then the result. Free: offset subtract, range check, then the bit-serial
// stride dividers; a free that fails the range check skips the dividers.
// Empty-stack allocate goes straight to the result. A finished result waits
// in the output register while the next item is taken. No clearing pass
// after reset or refill: stack entries below the lowest fill reached since
// refill read as their refill value, so the block is ready right after
// reset.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator
  import dsa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [ADDR_W-1:0]     in_host_handle,
  input  logic [ADDR_W-1:0]     in_device_handle,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [ADDR_W-1:0]     out_host_addr,
  output logic [ADDR_W-1:0]     out_device_addr
);

  localparam int unsigned IW = $clog2(MAX_SLOTS);      // slot index
  localparam int unsigned FW = $clog2(MAX_SLOTS + 1);  // fill count
  localparam int unsigned PW = IW + STRIDE_W;           // index * stride
  localparam int unsigned LW = FW + STRIDE_W;           // count * stride

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC_RD, S_ALLOC_ADD, S_FREE_SUB, S_FREE_CMP, S_FREE_DIV, S_OUT
  } state_t;

  // configuration
  logic [ADDR_W-1:0]   cpu_base_r;
  logic [ADDR_W-1:0]   gpu_base_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [COUNT_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_base_r <= '0;
      gpu_base_r <= '0;
      stride_r   <= STRIDE_RST;
      count_r    <= COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CPU_BASE:    cpu_base_r <= cfg_wdata;
        CFG_GPU_BASE:    gpu_base_r <= cfg_wdata;
        CFG_SLOT_STRIDE: stride_r   <= cfg_wdata[STRIDE_W-1:0];
        CFG_SLOT_COUNT:  count_r    <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [STRIDE_W-1:0] stride_eff;
  logic [FW-1:0]       n_eff;
  logic [FW-1:0]       n_refill;
  logic                refill;

  assign stride_eff = (stride_r == '0) ? STRIDE_W'(1) : stride_r;
  assign n_eff      = FW'(dsa_eff_count(count_r, MAX_SLOTS));
  assign n_refill   = FW'(dsa_eff_count(cfg_wdata[COUNT_W-1:0], MAX_SLOTS));
  assign refill     = cfg_we && (cfg_index == CFG_SLOT_COUNT);

  // datapath registers
  state_t            state_r;
  logic [FW-1:0]     fill_r;
  logic [FW-1:0]     min_fill_r;   // lowest fill since refill
  logic [IW-1:0]     pos_r;
  logic              pristine_r;
  logic [ADDR_W-1:0] host_h_r;
  logic [ADDR_W-1:0] dev_h_r;
  logic [ADDR_W-1:0] off_h_r;
  logic [ADDR_W-1:0] off_d_r;
  logic [LW-1:0]     lim_r;
  logic [PW-1:0]     prod_r;
  status_t           res_status_r;
  logic [ADDR_W-1:0] res_host_r;
  logic [ADDR_W-1:0] res_dev_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_host_r;
  logic [ADDR_W-1:0] out_dev_r;

  logic              accept;
  logic [FW-1:0]     top_pos;
  logic [FW-1:0]     pris_full;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     ram_rdata;
  logic              ram_we;
  logic              in_range;
  logic              div_start;
  logic              div_done_h;
  logic              div_done_d;
  logic [IW-1:0]     quo_h;
  logic [IW-1:0]     quo_d;
  logic              q_match;
  logic              stack_room;

  assign in_ready = rst_n && (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign top_pos  = fill_r - FW'(1);

  // entry never overwritten since refill holds n-1-pos
  assign pris_full = n_eff - FW'(1) - FW'(pos_r);
  assign idx       = pristine_r ? pris_full[IW-1:0] : ram_rdata;

  assign in_range   = (off_h_r < ADDR_W'(lim_r)) && (off_d_r < ADDR_W'(lim_r));
  assign div_start  = (state_r == S_FREE_CMP) && in_range;
  assign q_match    = (quo_h == quo_d);
  assign stack_room = (fill_r < n_eff);
  // push is written before any later pop reads the RAM, no bypass needed
  assign ram_we     = (state_r == S_FREE_DIV) && div_done_h && q_match && stack_room;

  dsa_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[IW-1:0]),
    .wdata (quo_h),
    .raddr (top_pos[IW-1:0]),
    .rdata (ram_rdata)
  );

  dsa_div #(.QW(IW)) u_div_host (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (off_h_r[PW-1:0]),
    .divisor  (stride_eff),
    .done     (div_done_h),
    .quotient (quo_h)
  );

  dsa_div #(.QW(IW)) u_div_dev (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (off_d_r[PW-1:0]),
    .divisor  (stride_eff),
    .done     (div_done_d),
    .quotient (quo_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= FW'(dsa_eff_count(COUNT_RST, MAX_SLOTS));
      min_fill_r  <= FW'(dsa_eff_count(COUNT_RST, MAX_SLOTS));
      out_valid_r <= 1'b0;
    end else begin
      // in S_OUT the output register is reloaded whenever it drains
      if (out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (refill) begin
        fill_r     <= n_refill;
        min_fill_r <= n_refill;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            host_h_r   <= in_host_handle;
            dev_h_r    <= in_device_handle;
            res_host_r <= '0;
            res_dev_r  <= '0;
            if (in_mode) begin
              state_r <= S_FREE_SUB;
            end else if (fill_r == '0) begin
              res_status_r <= ST_EMPTY;
              state_r      <= S_OUT;
            end else begin
              // pop: RAM read of top_pos issued this cycle
              pos_r      <= top_pos[IW-1:0];
              pristine_r <= (top_pos < min_fill_r);
              fill_r     <= top_pos;
              if (top_pos < min_fill_r) begin
                min_fill_r <= top_pos;
              end
              state_r <= S_ALLOC_RD;
            end
          end
        end
        S_ALLOC_RD: begin
          prod_r  <= PW'(idx) * PW'(stride_eff);
          state_r <= S_ALLOC_ADD;
        end
        S_ALLOC_ADD: begin
          res_host_r   <= cpu_base_r + ADDR_W'(prod_r);
          res_dev_r    <= gpu_base_r + ADDR_W'(prod_r);
          res_status_r <= ST_OK;
          state_r      <= S_OUT;
        end
        S_FREE_SUB: begin
          off_h_r <= host_h_r - cpu_base_r;
          off_d_r <= dev_h_r - gpu_base_r;
          lim_r   <= LW'(n_eff) * LW'(stride_eff);
          state_r <= S_FREE_CMP;
        end
        S_FREE_CMP: begin
          // quotient at or above the count: reject without dividing
          if (in_range) begin
            state_r <= S_FREE_DIV;
          end else begin
            res_status_r <= ST_MISMATCH;
            state_r      <= S_OUT;
          end
        end
        S_FREE_DIV: begin
          if (div_done_h && div_done_d) begin
            if (!q_match) begin
              res_status_r <= ST_MISMATCH;
            end else if (!stack_room) begin
              res_status_r <= ST_FULL;
            end else begin
              res_status_r <= ST_OK;
              fill_r       <= fill_r + FW'(1);
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_host_r   <= res_host_r;
            out_dev_r    <= res_dev_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_host_addr   = out_host_r;
  assign out_device_addr = out_dev_r;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the descriptor slot allocator. A queue-fed driver
// sends allocate and free requests while a clocked monitor compares every
// response against an in-bench free-stack predictor. Register settings
// change between phases once the block has drained, and both sides idle at
// random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import dsa_pkg::*;

  localparam int          CLK_PERIOD     = 8;
  localparam int          RESET_CYCLES   = 9;
  localparam int          MAX_IDLE       = 4;
  localparam int          SETTLE_CYCLES  = 20;
  localparam int          TOTAL_REQUESTS = 1350;
  localparam int          SLOT_IDX_W     = $clog2(MAX_SLOTS_DEF);
  localparam logic        MODE_ALLOC     = 1'b0;
  localparam logic        MODE_FREE      = 1'b1;

  typedef struct {
    logic              mode;
    logic [ADDR_W-1:0] host;
    logic [ADDR_W-1:0] dev;
  } slot_request_t;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] host;
    logic [ADDR_W-1:0] dev;
  } slot_response_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_mode = 1'b0;
  logic [ADDR_W-1:0]     in_host_handle = '0;
  logic [ADDR_W-1:0]     in_device_handle = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_status;
  logic [ADDR_W-1:0]     out_host_addr;
  logic [ADDR_W-1:0]     out_device_addr;

  descriptor_slot_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_host_handle  (in_host_handle),
    .in_device_handle(in_device_handle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_host_addr   (out_host_addr),
    .out_device_addr (out_device_addr)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor copy of registers and free stack
  logic [ADDR_W-1:0]     cpu_base_r;
  logic [ADDR_W-1:0]     gpu_base_r;
  logic [STRIDE_W-1:0]   stride_r;
  logic [COUNT_W-1:0]    count_r;
  logic [SLOT_IDX_W-1:0] free_slots [MAX_SLOTS_DEF];
  int unsigned           free_depth;

  slot_request_t  queued_requests[$];
  slot_response_t awaited_responses[$];
  slot_request_t  taken_req;
  slot_response_t exp_rsp;
  slot_response_t got_rsp;

  bit no_idle = 1'b0;
  int gap_left = 0;
  int hold_left = 0;
  int stall_draw;
  int requests_made = 0;
  int allocs_sent = 0;
  int frees_sent = 0;
  int settings_used = 0;
  int fail_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  function automatic logic [ADDR_W-1:0] eff_stride();
    return (stride_r == '0) ? ADDR_W'(1) : ADDR_W'(stride_r);
  endfunction

  function automatic int unsigned eff_count();
    return (count_r > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(count_r);
  endfunction

  function automatic void refill_free_slots();
    int unsigned n;
    n = eff_count();
    for (int unsigned i = 0; i < n; i++)
      free_slots[i] = SLOT_IDX_W'(n - 1 - i);
    free_depth = n;
  endfunction

  function automatic void reset_registers();
    cpu_base_r = '0;
    gpu_base_r = '0;
    stride_r   = STRIDE_RST;
    count_r    = COUNT_RST;
    refill_free_slots();
  endfunction

  // response for one accepted request; updates the free stack
  function automatic slot_response_t serve_request(slot_request_t req);
    slot_response_t    rsp;
    logic [ADDR_W-1:0] stride;
    logic [ADDR_W-1:0] host_q;
    logic [ADDR_W-1:0] dev_q;
    logic [ADDR_W-1:0] idx;
    int unsigned       n;
    stride = eff_stride();
    n = eff_count();
    rsp.status = ST_OK;
    rsp.host = '0;
    rsp.dev = '0;
    if (req.mode == MODE_ALLOC) begin
      if (free_depth == 0) begin
        rsp.status = ST_EMPTY;
      end else begin
        free_depth--;
        idx = ADDR_W'(free_slots[free_depth]);
        rsp.host = cpu_base_r + idx * stride;
        rsp.dev = gpu_base_r + idx * stride;
      end
    end else begin
      host_q = (req.host - cpu_base_r) / stride;
      dev_q = (req.dev - gpu_base_r) / stride;
      // handle check wins over the full check
      if (host_q != dev_q || host_q >= ADDR_W'(n)) begin
        rsp.status = ST_MISMATCH;
      end else if (free_depth >= n) begin
        rsp.status = ST_FULL;
      end else begin
        free_slots[free_depth] = host_q[SLOT_IDX_W-1:0];
        free_depth++;
      end
    end
    return rsp;
  endfunction

  // driver: one request per handshake, random gap before each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= $urandom_range(MAX_IDLE, 0);
    end else begin
      if (in_valid && in_ready) begin
        taken_req.mode = in_mode;
        taken_req.host = in_host_handle;
        taken_req.dev = in_device_handle;
        exp_rsp = serve_request(taken_req);
        awaited_responses = {awaited_responses, exp_rsp};
        if (in_mode == MODE_ALLOC) allocs_sent++;
        else frees_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (queued_requests.size() != 0) begin
          taken_req = queued_requests.pop_front();
          in_mode <= taken_req.mode;
          in_host_handle <= taken_req.host;
          in_device_handle <= taken_req.dev;
          in_valid <= 1'b1;
          gap_left <= no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: stalls each response a random number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && out_ready) begin
      if (awaited_responses.size() == 0) begin
        $error("unexpected response: status %0d host %h device %h",
               out_status, out_host_addr, out_device_addr);
        fail_count++;
      end else begin
        got_rsp = awaited_responses.pop_front();
        status_seen[got_rsp.status]++;
        if (out_status !== got_rsp.status) begin
          $error("status: expected %0d, got %0d", got_rsp.status, out_status);
          fail_count++;
        end
        if (out_host_addr !== got_rsp.host) begin
          $error("host_addr: expected %h, got %h", got_rsp.host, out_host_addr);
          fail_count++;
        end
        if (out_device_addr !== got_rsp.dev) begin
          $error("device_addr: expected %h, got %h", got_rsp.dev, out_device_addr);
          fail_count++;
        end
      end
      stall_draw = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
      out_ready <= (stall_draw == 0);
      hold_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
    end else if (out_valid && !out_ready) begin
      if (hold_left == 0) out_ready <= 1'b1;
      else hold_left <= hold_left - 1;
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_item(logic mode, logic [ADDR_W-1:0] host,
                                    logic [ADDR_W-1:0] dev);
    slot_request_t req;
    req.mode = mode;
    req.host = host;
    req.dev = dev;
    queued_requests = {queued_requests, req};
    requests_made++;
  endfunction

  function automatic void push_alloc();
    push_item(MODE_ALLOC, rand_addr(), rand_addr());
  endfunction

  // free built from slot indices plus byte offsets inside the slot
  function automatic void push_free(int unsigned host_idx, int unsigned dev_idx,
                                    logic [ADDR_W-1:0] host_rem,
                                    logic [ADDR_W-1:0] dev_rem);
    logic [ADDR_W-1:0] s;
    s = eff_stride();
    push_item(MODE_FREE, cpu_base_r + ADDR_W'(host_idx) * s + host_rem,
              gpu_base_r + ADDR_W'(dev_idx) * s + dev_rem);
  endfunction

  task automatic wait_quiet();
    do begin
      @(posedge clk);
    end while (queued_requests.size() != 0 || in_valid || awaited_responses.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CPU_BASE:    cpu_base_r = val;
      CFG_GPU_BASE:    gpu_base_r = val;
      CFG_SLOT_STRIDE: stride_r = val[STRIDE_W-1:0];
      CFG_SLOT_COUNT: begin
        count_r = val[COUNT_W-1:0];
        refill_free_slots();
      end
      default: ;
    endcase
  endtask

  // count goes last since it refills the stack
  task automatic configure(logic [ADDR_W-1:0] cpu, logic [ADDR_W-1:0] gpu,
                           logic [STRIDE_W-1:0] stride, logic [COUNT_W-1:0] count);
    wait_quiet();
    write_reg(CFG_CPU_BASE, cpu);
    write_reg(CFG_GPU_BASE, gpu);
    write_reg(CFG_SLOT_STRIDE, CFG_DATA_W'(stride));
    write_reg(CFG_SLOT_COUNT, CFG_DATA_W'(count));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [ADDR_W-1:0] pick_base();
    case ($urandom_range(3, 0))
      0:       return '0;
      1:       return '1;
      default: return rand_addr();
    endcase
  endfunction

  function automatic logic [STRIDE_W-1:0] pick_stride();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return STRIDE_W'(1);
      2:       return '1;
      3:       return STRIDE_RST;
      default: return STRIDE_W'($urandom_range(65535, 1));
    endcase
  endfunction

  // mostly small pools so that both empty and full are reached
  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return COUNT_W'(1);
      2:       return COUNT_W'(MAX_SLOTS_DEF);
      3:       return $urandom_range(1, 0) ? '1 : COUNT_W'($urandom_range(2046, 1025));
      default: return COUNT_W'($urandom_range(16, 2));
    endcase
  endfunction

  function automatic void random_request(int alloc_pct);
    int unsigned       n;
    int unsigned       idx;
    int unsigned       kind;
    logic [ADDR_W-1:0] s;
    n = eff_count();
    s = eff_stride();
    kind = $urandom_range(99, 0);
    if ($urandom_range(99, 0) < alloc_pct) begin
      push_alloc();
    end else if (kind < 80 && n > 0) begin
      idx = $urandom_range(n - 1, 0);
      push_free(idx, idx, $urandom_range(32'(s - 1), 0), $urandom_range(32'(s - 1), 0));
    end else if (kind < 88) begin
      idx = $urandom_range(MAX_SLOTS_DEF - 1, 0);
      push_free(idx, idx + 1 + $urandom_range(5, 0), 0, $urandom_range(32'(s - 1), 0));
    end else if (kind < 94) begin
      idx = n + $urandom_range(3, 0);
      push_free(idx, idx, 0, 0);
    end else begin
      push_item(MODE_FREE, rand_addr(), rand_addr());
    end
  endfunction

  initial begin
    int alloc_pct;
    int batch;
    reset_registers();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: in-order handout, remainder dropped, bad handles, full
    push_alloc();
    push_alloc();
    push_item(MODE_ALLOC, '1, '1);
    push_free(1, 1, 31, 0);
    push_free(2, 1, 0, 0);
    push_free(MAX_SLOTS_DEF, MAX_SLOTS_DEF, 0, 0);
    push_item(MODE_FREE, '1, '1);
    push_free(0, 0, 0, 0);
    push_free(5, 5, 0, 0);    // double free, still room
    push_free(7, 7, 0, 0);
    push_free(3, 4, 0, 0);    // bad handles on a full stack

    // zero stride and address wrap, two slots
    configure('1, ADDR_W'(5), '0, COUNT_W'(2));
    push_alloc();
    push_alloc();
    push_item(MODE_ALLOC, '0, '1);
    push_free(1, 1, 0, 0);
    push_free(0, 0, 0, 0);
    push_free(1, 1, 0, 0);

    // empty pool
    configure('0, '1, '1, '0);
    push_alloc();
    push_free(0, 0, 65534, 0);

    // count above the stack depth
    configure(rand_addr(), rand_addr(), STRIDE_W'(1), '1);
    push_alloc();
    push_free(MAX_SLOTS_DEF - 1, MAX_SLOTS_DEF - 1, 0, 0);
    push_alloc();
    push_free(MAX_SLOTS_DEF, MAX_SLOTS_DEF, 0, 0);

    while (requests_made < TOTAL_REQUESTS) begin
      configure(pick_base(), pick_base(), pick_stride(), pick_count());
      no_idle = ($urandom_range(3, 0) == 0);
      alloc_pct = $urandom_range(80, 20);
      batch = $urandom_range(60, 15);
      repeat (batch) random_request(alloc_pct);
    end

    wait_quiet();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("Served %0d allocates and %0d frees over %0d register settings",
             allocs_sent, frees_sent, settings_used);
    $display("Responses: %0d ok, %0d empty, %0d mismatch, %0d full",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_MISMATCH],
             status_seen[ST_FULL]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: run did not drain");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
src/dsa_pkg.sv
src/dsa_ram.sv
src/dsa_div.sv
src/descriptor_slot_allocator.sv
dv/testbench.sv
